/* rtl/rlt_pkg.sv */
`default_nettype none
package rlt_pkg;

    localparam int LOCK_ENTRIES = 64;
    localparam int WAIT_SLOTS   = 256;
    localparam int KEY_BITS     = 64;
    localparam int DEPTH_CAP    = 64;

    localparam int IDX_W = $clog2(LOCK_ENTRIES);
    localparam int WS_W  = $clog2(WAIT_SLOTS);
    localparam int CNT_W = $clog2(LOCK_ENTRIES + 1);
    localparam int SCN_W = IDX_W + 1;

    localparam logic [2:0] FN_ACQUIRE = 3'd0;
    localparam logic [2:0] FN_RESUME  = 3'd1;
    localparam logic [2:0] FN_RELEASE = 3'd2;
    localparam logic [2:0] FN_REL_ALL = 3'd3;
    localparam logic [2:0] FN_CHECK   = 3'd4;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_WAIT     = 3'd1;
    localparam logic [2:0] STS_DEADLOCK = 3'd2;
    localparam logic [2:0] STS_TIMEOUT  = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;

    localparam logic [1:0] MD_NONE = 2'd0;
    localparam logic [1:0] MD_SH   = 2'd1;
    localparam logic [1:0] MD_EX   = 2'd2;

    localparam logic [6:0] DEPTH_RESET = 7'd64;
    localparam logic [7:0] WAITERS_MAX = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WREQ,
        S_WCHK,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [31:0]         tab;
        logic [KEY_BITS-1:0] key;
        logic [31:0]         holder;
        logic [1:0]          mode;
        logic [7:0]          waiters;
    } entry_t;

    function automatic logic conflicts(input logic [1:0] held, input logic [1:0] want);
        conflicts = (held != MD_NONE) && !((held == MD_SH) && (want == MD_SH));
    endfunction

endpackage
`default_nettype wire

/* rtl/row_lock_table_with_deadlock_check_core.sv */
// channel | signals                                         | direction
// cfg     | cfg_we, cfg_wdata                               | in, no wait
// in      | in_valid, in_ready, func, tbl_id, row_key, xid, | in
//         | req_mode, timed_out                             |
// out     | out_valid, out_ready, status, held_mode, holder, | out
//         | wake, entries_in_use                            |
// a beat on func 0,1,2,4 scans the table one entry a cycle through the entry ram read
// port, and follows wait-for links as needed (up to 64)
// a valid release-all always sweeps the whole table
// invalid requests skip the scan and go straight to S_FIN; in_ready only when idle
// reset clears valid bits of the table and of the wait-for slots at once, no clearing pass
// a result waits in the output register until taken while the next beat is accepted
`default_nettype none
module row_lock_table_with_deadlock_check_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [31:0] tbl_id,
    input  wire logic [63:0] row_key,
    input  wire logic [31:0] xid,
    input  wire logic        req_mode,
    input  wire logic        timed_out,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [1:0]       held_mode,
    output logic [31:0]      holder,
    output logic             wake,
    output logic [6:0]       entries_in_use
);

    localparam int N = rlt_pkg::LOCK_ENTRIES;

    rlt_pkg::state_t state_reg, state_next;

    logic [6:0]                   depth_reg;
    logic [N-1:0]                 vld_reg;
    logic [rlt_pkg::WAIT_SLOTS-1:0] wf_vld_reg;
    logic [rlt_pkg::CNT_W-1:0]    used_reg;

    logic [2:0]                   fn_reg;
    logic [31:0]                  tab_reg;
    logic [rlt_pkg::KEY_BITS-1:0] key_reg;
    logic [31:0]                  xid_reg;
    logic [1:0]                   want_reg;
    logic                         exp_reg;

    logic [rlt_pkg::SCN_W-1:0]    cnt_reg;
    logic                         chk_vld_reg;
    logic [rlt_pkg::IDX_W-1:0]    chk_idx_reg;
    logic                         free_found_reg;
    logic [rlt_pkg::IDX_W-1:0]    free_idx_reg;
    logic                         found_reg;
    logic [rlt_pkg::IDX_W-1:0]    e_idx_reg;
    rlt_pkg::entry_t              e_reg;

    logic [31:0]                  cur_reg;
    logic [6:0]                   walk_d_reg;
    logic                         wf_vq_reg;

    logic [2:0]                   rs_status_reg;
    logic [1:0]                   rs_hmode_reg;
    logic [31:0]                  rs_holder_reg;
    logic                         rs_wake_reg;

    logic                         out_valid_reg;
    logic [2:0]                   o_status_reg;
    logic [1:0]                   o_hmode_reg;
    logic [31:0]                  o_holder_reg;
    logic                         o_wake_reg;
    logic [6:0]                   o_used_reg;

    rlt_pkg::entry_t              ent_rdata, ent_wdata;
    logic                         ent_we;
    logic [rlt_pkg::IDX_W-1:0]    ent_waddr;
    logic [31:0]                  wf_rdata;
    logic                         wf_we;
    logic [31:0]                  wf_wdata;

    logic                         in_fire, issue, hit, last_chk, drop_hit;
    logic                         vld_set, vld_clr, used_inc, used_dec;
    logic [rlt_pkg::IDX_W-1:0]    vld_idx;
    logic                         wf_set, wf_clr;
    logic                         do_wait, walk_go, out_load;
    logic                         set_res;
    logic [2:0]                   res_status;
    logic [1:0]                   res_hmode;
    logic [31:0]                  res_holder;
    logic                         wake_or;
    logic [6:0]                   lim;
    logic [31:0]                  nxt;
    logic [rlt_pkg::WS_W-1:0]     xid_slot;
    logic                         req_ok;

    assign in_ready = (state_reg == rlt_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign lim      = (depth_reg > 7'(rlt_pkg::DEPTH_CAP)) ? 7'(rlt_pkg::DEPTH_CAP) : depth_reg;
    assign xid_slot = xid_reg[rlt_pkg::WS_W-1:0];
    assign nxt      = wf_vq_reg ? wf_rdata : 32'd0;
    assign issue    = (cnt_reg < rlt_pkg::SCN_W'(N));
    assign last_chk = chk_vld_reg && (chk_idx_reg == rlt_pkg::IDX_W'(N - 1));
    assign hit      = chk_vld_reg && vld_reg[chk_idx_reg] && (ent_rdata.tab == tab_reg)
                      && (ent_rdata.key == key_reg);
    assign drop_hit = chk_vld_reg && vld_reg[chk_idx_reg] && (ent_rdata.holder == xid_reg);
    assign out_load = (state_reg == rlt_pkg::S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        req_ok = (xid != 32'd0) && (row_key[rlt_pkg::KEY_BITS-1:0] != '0);
        case (func)
            rlt_pkg::FN_ACQUIRE, rlt_pkg::FN_RESUME, rlt_pkg::FN_RELEASE: ;
            rlt_pkg::FN_REL_ALL: req_ok = (xid != 32'd0);
            rlt_pkg::FN_CHECK:   req_ok = (row_key[rlt_pkg::KEY_BITS-1:0] != '0);
            default:             req_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ent_we     = 1'b0;
        ent_waddr  = e_idx_reg;
        ent_wdata  = e_reg;
        vld_set    = 1'b0;
        vld_clr    = 1'b0;
        vld_idx    = e_idx_reg;
        used_inc   = 1'b0;
        used_dec   = 1'b0;
        wf_set     = 1'b0;
        wf_clr     = 1'b0;
        wf_wdata   = e_reg.holder;
        do_wait    = 1'b0;
        walk_go    = 1'b0;
        set_res    = 1'b0;
        res_status = rlt_pkg::STS_OK;
        res_hmode  = rlt_pkg::MD_NONE;
        res_holder = 32'd0;
        wake_or    = 1'b0;
        case (state_reg)
            rlt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = req_ok ? rlt_pkg::S_SCAN : rlt_pkg::S_FIN;
                end
            end
            rlt_pkg::S_SCAN:
            begin
                if (fn_reg == rlt_pkg::FN_REL_ALL)
                begin
                    ent_waddr = chk_idx_reg;
                    vld_idx   = chk_idx_reg;
                    ent_wdata = ent_rdata;
                    if (drop_hit)
                    begin
                        if (ent_rdata.waiters != 8'd0)
                        begin
                            ent_we           = 1'b1;
                            ent_wdata.holder = 32'd0;
                            ent_wdata.mode   = rlt_pkg::MD_NONE;
                            wake_or          = 1'b1;
                        end
                        else
                        begin
                            vld_clr  = 1'b1;
                            used_dec = 1'b1;
                        end
                    end
                    if (last_chk)
                    begin
                        state_next = rlt_pkg::S_FIN;
                    end
                end
                else if (hit || last_chk)
                begin
                    state_next = rlt_pkg::S_DECIDE;
                end
            end
            rlt_pkg::S_DECIDE:
            begin
                state_next = rlt_pkg::S_FIN;
                set_res    = 1'b1;
                case (fn_reg)
                    rlt_pkg::FN_ACQUIRE, rlt_pkg::FN_RESUME:
                    begin
                        if (!found_reg)
                        begin
                            wf_clr = (fn_reg == rlt_pkg::FN_RESUME);
                            if (free_found_reg)
                            begin
                                ent_we    = 1'b1;
                                ent_waddr = free_idx_reg;
                                vld_idx   = free_idx_reg;
                                vld_set   = 1'b1;
                                used_inc  = 1'b1;
                                ent_wdata = '{tab: tab_reg, key: key_reg, holder: xid_reg,
                                              mode: want_reg, waiters: 8'd0};
                            end
                            else
                            begin
                                res_status = rlt_pkg::STS_FULL;
                            end
                        end
                        else if (fn_reg == rlt_pkg::FN_ACQUIRE)
                        begin
                            if (e_reg.holder == xid_reg)
                            begin
                                if (want_reg == rlt_pkg::MD_EX && e_reg.mode == rlt_pkg::MD_SH)
                                begin
                                    ent_we         = 1'b1;
                                    ent_wdata.mode = rlt_pkg::MD_EX;
                                end
                            end
                            else if (e_reg.holder == 32'd0)
                            begin
                                ent_we           = 1'b1;
                                ent_wdata.holder = xid_reg;
                                ent_wdata.mode   = want_reg;
                            end
                            else if (rlt_pkg::conflicts(e_reg.mode, want_reg))
                            begin
                                if (lim == 7'd0)
                                begin
                                    do_wait = 1'b1;
                                end
                                else
                                begin
                                    walk_go    = 1'b1;
                                    set_res    = 1'b0;
                                    state_next = rlt_pkg::S_WREQ;
                                end
                            end
                        end
                        else
                        begin
                            if (e_reg.holder != 32'd0 && e_reg.holder != xid_reg
                                && rlt_pkg::conflicts(e_reg.mode, want_reg))
                            begin
                                if (exp_reg)
                                begin
                                    wf_clr     = 1'b1;
                                    ent_we     = 1'b1;
                                    res_status = rlt_pkg::STS_TIMEOUT;
                                    if (e_reg.waiters != 8'd0)
                                    begin
                                        ent_wdata.waiters = e_reg.waiters - 8'd1;
                                    end
                                end
                                else
                                begin
                                    res_status = rlt_pkg::STS_WAIT;
                                end
                            end
                            else
                            begin
                                wf_clr = 1'b1;
                                ent_we = 1'b1;
                                if (e_reg.waiters != 8'd0)
                                begin
                                    ent_wdata.waiters = e_reg.waiters - 8'd1;
                                end
                                if (e_reg.holder == 32'd0)
                                begin
                                    ent_wdata.holder = xid_reg;
                                    ent_wdata.mode   = want_reg;
                                end
                            end
                        end
                    end
                    rlt_pkg::FN_RELEASE:
                    begin
                        if (found_reg && e_reg.holder == xid_reg)
                        begin
                            if (e_reg.waiters != 8'd0)
                            begin
                                ent_we           = 1'b1;
                                ent_wdata.holder = 32'd0;
                                ent_wdata.mode   = rlt_pkg::MD_NONE;
                                wake_or          = 1'b1;
                            end
                            else
                            begin
                                vld_clr  = 1'b1;
                                used_dec = 1'b1;
                            end
                        end
                    end
                    rlt_pkg::FN_CHECK:
                    begin
                        if (found_reg && e_reg.holder != 32'd0)
                        begin
                            res_hmode  = e_reg.mode;
                            res_holder = e_reg.holder;
                        end
                    end
                    default: ;
                endcase
            end
            rlt_pkg::S_WREQ:
            begin
                state_next = rlt_pkg::S_WCHK;
            end
            rlt_pkg::S_WCHK:
            begin
                if (nxt == 32'd0 || (walk_d_reg + 7'd1) >= lim)
                begin
                    if (nxt == xid_reg)
                    begin
                        set_res    = 1'b1;
                        res_status = rlt_pkg::STS_DEADLOCK;
                    end
                    else
                    begin
                        do_wait = 1'b1;
                    end
                    state_next = rlt_pkg::S_FIN;
                end
                else if (nxt == xid_reg)
                begin
                    set_res    = 1'b1;
                    res_status = rlt_pkg::STS_DEADLOCK;
                    state_next = rlt_pkg::S_FIN;
                end
                else
                begin
                    state_next = rlt_pkg::S_WREQ;
                end
            end
            rlt_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    state_next = rlt_pkg::S_IDLE;
                end
            end
            default: state_next = rlt_pkg::S_IDLE;
        endcase
        if (do_wait)
        begin
            set_res    = 1'b1;
            res_status = rlt_pkg::STS_WAIT;
            wf_set     = 1'b1;
            wf_wdata   = e_reg.holder;
            ent_we     = 1'b1;
            ent_waddr  = e_idx_reg;
            ent_wdata  = e_reg;
            if (e_reg.waiters != rlt_pkg::WAITERS_MAX)
            begin
                ent_wdata.waiters = e_reg.waiters + 8'd1;
            end
        end
    end

    assign wf_we = wf_set || wf_clr;

    rlt_ram #(
        .WIDTH ($bits(rlt_pkg::entry_t)),
        .DEPTH (N)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (cnt_reg[rlt_pkg::IDX_W-1:0]),
        .rdata (ent_rdata)
    );

    rlt_ram #(
        .WIDTH (32),
        .DEPTH (rlt_pkg::WAIT_SLOTS)
    ) u_wf_ram (
        .clk   (clk),
        .we    (wf_we),
        .waddr (xid_slot),
        .wdata (wf_wdata),
        .raddr (cur_reg[rlt_pkg::WS_W-1:0]),
        .rdata (wf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rlt_pkg::S_IDLE;
            depth_reg     <= rlt_pkg::DEPTH_RESET;
            vld_reg       <= '0;
            wf_vld_reg    <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                depth_reg <= cfg_wdata;
            end
            if (vld_set)
            begin
                vld_reg[vld_idx] <= 1'b1;
            end
            if (vld_clr)
            begin
                vld_reg[vld_idx] <= 1'b0;
            end
            if (wf_set)
            begin
                wf_vld_reg[xid_slot] <= 1'b1;
            end
            if (wf_clr)
            begin
                wf_vld_reg[xid_slot] <= 1'b0;
            end
            if (used_inc)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (used_dec && used_reg != '0)
            begin
                used_reg <= used_reg - 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            chk_vld_reg <= (state_reg == rlt_pkg::S_SCAN) && issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fn_reg         <= func;
            tab_reg        <= tbl_id;
            key_reg        <= row_key[rlt_pkg::KEY_BITS-1:0];
            xid_reg        <= xid;
            want_reg       <= req_mode ? rlt_pkg::MD_EX : rlt_pkg::MD_SH;
            exp_reg        <= timed_out;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            rs_status_reg  <= rlt_pkg::STS_OK;
            rs_hmode_reg   <= rlt_pkg::MD_NONE;
            rs_holder_reg  <= 32'd0;
            rs_wake_reg    <= 1'b0;
        end
        if (state_reg == rlt_pkg::S_SCAN)
        begin
            chk_idx_reg <= cnt_reg[rlt_pkg::IDX_W-1:0];
            if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (chk_vld_reg && !vld_reg[chk_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= chk_idx_reg;
            end
            if (hit)
            begin
                found_reg <= 1'b1;
                e_idx_reg <= chk_idx_reg;
                e_reg     <= ent_rdata;
            end
        end
        if (walk_go)
        begin
            cur_reg    <= e_reg.holder;
            walk_d_reg <= 7'd0;
        end
        if (state_reg == rlt_pkg::S_WREQ)
        begin
            wf_vq_reg <= wf_vld_reg[cur_reg[rlt_pkg::WS_W-1:0]];
        end
        if (state_reg == rlt_pkg::S_WCHK)
        begin
            cur_reg    <= nxt;
            walk_d_reg <= walk_d_reg + 7'd1;
        end
        if (set_res)
        begin
            rs_status_reg <= res_status;
            rs_hmode_reg  <= res_hmode;
            rs_holder_reg <= res_holder;
        end
        if (wake_or)
        begin
            rs_wake_reg <= 1'b1;
        end
        if (out_load)
        begin
            o_status_reg <= rs_status_reg;
            o_hmode_reg  <= rs_hmode_reg;
            o_holder_reg <= rs_holder_reg;
            o_wake_reg   <= rs_wake_reg;
            o_used_reg   <= 7'(used_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign held_mode      = o_hmode_reg;
    assign holder         = o_holder_reg;
    assign wake           = o_wake_reg;
    assign entries_in_use = o_used_reg;

`ifndef SYNTHESIS
    a_used_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) == $countones(vld_reg))
        else $error("entry count differs from valid bits");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlt_pkg::S_WCHK) |-> (walk_d_reg < lim))
        else $error("wait-for walk past depth limit");
    a_bad_req_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func > rlt_pkg::FN_CHECK) |=> (state_reg == rlt_pkg::S_FIN))
        else $error("unknown request did not finish at once");
    a_scan_no_write_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlt_pkg::S_SCAN && fn_reg != rlt_pkg::FN_REL_ALL) |-> !ent_we)
        else $error("table written during lookup");
`endif

endmodule
`default_nettype wire

/* rtl/rlt_ram.sv */
`default_nettype none
module rlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
